[src/ev_charge_session_controller_core_macros.svh]
// Assertion macros shared by the checker files.
`ifndef EV_CHARGE_SESSION_CONTROLLER_CORE_MACROS_SVH
`define EV_CHARGE_SESSION_CONTROLLER_CORE_MACROS_SVH

// Property checked while out of reset.
`define EVCSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property that also covers the reset cycles.
`define EVCSC_ASSERT_RESET(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/evcsc_pkg.sv]
// ----------------------------------------------------------------------------
// evcsc_pkg
// Types, codes and helpers of the charge session controller.
// ----------------------------------------------------------------------------
package evcsc_pkg;

    localparam int unsigned CARD_FIELD_BITS = 32;

    typedef struct packed {
        logic [3:0]                 pilot_volts;
        logic [1:0]                 pilot_waveform;
        logic                       stop_pressed;
        logic                       charge_pressed;
        logic                       card_inserted;
        logic [CARD_FIELD_BITS-1:0] card_number;
        logic                       card_authorized;
    } in_item_t;

    typedef struct packed {
        logic [3:0] session_phase;
        logic [1:0] pilot_drive;
        logic       contactor_closed;
        logic       hatch_locked;
        logic [1:0] charge_lamp;
        logic       available_lamp;
        logic       fault_lamp;
        logic [1:0] plug_lamp;
        logic [2:0] user_prompt;
    } out_item_t;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_WAIT   = 9'b000000010,
        PH_A      = 9'b000000100,
        PH_B      = 9'b000001000,
        PH_C      = 9'b000010000,
        PH_D      = 9'b000100000,
        PH_E      = 9'b001000000,
        PH_F      = 9'b010000000,
        PH_UNPLUG = 9'b100000000
    } phase_t;

    // Reported phase codes
    localparam logic [3:0] PHC_IDLE   = 4'd0;
    localparam logic [3:0] PHC_WAIT   = 4'd1;
    localparam logic [3:0] PHC_A      = 4'd2;
    localparam logic [3:0] PHC_B      = 4'd3;
    localparam logic [3:0] PHC_C      = 4'd4;
    localparam logic [3:0] PHC_D      = 4'd5;
    localparam logic [3:0] PHC_E      = 4'd6;
    localparam logic [3:0] PHC_F      = 4'd7;
    localparam logic [3:0] PHC_UNPLUG = 4'd8;

    // Pilot generator drive
    localparam logic [1:0] DRV_NONE   = 2'd0;
    localparam logic [1:0] DRV_DC12   = 2'd1;
    localparam logic [1:0] DRV_AC1K   = 2'd2;
    localparam logic [1:0] DRV_CLOSED = 2'd3;

    // Charge lamp
    localparam logic [1:0] LAMP_OFF   = 2'd0;
    localparam logic [1:0] LAMP_GREEN = 2'd1;
    localparam logic [1:0] LAMP_RED   = 2'd2;
    localparam logic [1:0] LAMP_BLINK = 2'd3;

    // Plug lamp
    localparam logic [1:0] PLUG_OFF      = 2'd0;
    localparam logic [1:0] PLUG_GREEN    = 2'd1;
    localparam logic [1:0] PLUG_RELEASED = 2'd2;

    // User prompt
    localparam logic [2:0] PR_NONE      = 3'd0;
    localparam logic [2:0] PR_INSERT    = 3'd1;
    localparam logic [2:0] PR_REMOVE    = 3'd2;
    localparam logic [2:0] PR_PLUG_IN   = 3'd3;
    localparam logic [2:0] PR_UNPLUG    = 3'd4;
    localparam logic [2:0] PR_WRONG_VEH = 3'd5;

    // Pilot waveform and levels
    localparam logic [1:0] WF_DC   = 2'd0;
    localparam logic [1:0] WF_AC1K = 2'd1;
    localparam logic [3:0] VOLTS_12 = 4'd12;
    localparam logic [3:0] VOLTS_9  = 4'd9;
    localparam logic [3:0] VOLTS_6  = 4'd6;

    localparam logic [7:0] TIMEOUT_RESET = 8'd8;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

    function automatic logic [3:0] phase_code(phase_t p);
        logic [3:0] code;
        unique case (p)
            PH_IDLE:   code = PHC_IDLE;
            PH_WAIT:   code = PHC_WAIT;
            PH_A:      code = PHC_A;
            PH_B:      code = PHC_B;
            PH_C:      code = PHC_C;
            PH_D:      code = PHC_D;
            PH_E:      code = PHC_E;
            PH_F:      code = PHC_F;
            PH_UNPLUG: code = PHC_UNPLUG;
            default:   code = PHC_IDLE;
        endcase
        return code;
    endfunction

endpackage

[src/ev_charge_session_controller_core.sv]
// ----------------------------------------------------------------------------
// ev_charge_session_controller_core
// Charge session controller: one result per one-second pilot/button/card
// sample.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one result, in order. The block takes
// one sample per clock cycle sustained while the result port is not stalled.
// A sample is held in the input register and its result in the result
// register; the phase transition and output latch update are done in a single
// pass of logic between the two registers. Either register stalls only while
// the stage after it is full and not being drained. The charge button timeout
// (cfg_wr_data, reset 8 ticks) is written through cfg_wr_en; the user must do
// so only while no sample is in flight, which the block does not enforce.
// CARD_BITS sets how many low card number bits are stored and compared (at
// most the 32 bits of the card field).
module ev_charge_session_controller_core #(
    parameter int unsigned CARD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  evcsc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output evcsc_pkg::out_item_t m_data
);

    logic                 in_valid;
    evcsc_pkg::in_item_t  in_data;
    logic                 out_free;
    logic                 advance;
    evcsc_pkg::out_item_t result;

    // Move a held sample into the result register and commit its state.
    assign advance = in_valid && out_free;

    evcsc_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    evcsc_session #(
        .CARD_BITS (CARD_BITS)
    ) u_session (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .in_data     (in_data),
        .result      (result)
    );

    evcsc_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .out_free (out_free)
    );

endmodule

[src/evcsc_in_stage.sv]
// ----------------------------------------------------------------------------
// evcsc_in_stage
// Input register: holds one accepted sample until the session logic takes it.
// ----------------------------------------------------------------------------
module evcsc_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  evcsc_pkg::in_item_t  s_data,
    input  logic                 advance,
    output logic                 in_valid,
    output evcsc_pkg::in_item_t  in_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    evcsc_pkg::in_item_t in_data_reg;

    // Take a new sample when empty or whenever the held one leaves this cycle.
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_data  = in_data_reg;

endmodule

[src/evcsc_session.sv]
// ----------------------------------------------------------------------------
// evcsc_session
// Session state machine, output latches and timeout register. Computes the
// result of one sample and commits the new state on advance.
// ----------------------------------------------------------------------------
module evcsc_session #(
    parameter int unsigned CARD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 advance,
    input  evcsc_pkg::in_item_t  in_data,
    output evcsc_pkg::out_item_t result
);

    localparam int unsigned CMP_BITS =
        (CARD_BITS < evcsc_pkg::CARD_FIELD_BITS) ? CARD_BITS : evcsc_pkg::CARD_FIELD_BITS;

    evcsc_pkg::phase_t   phase_reg, phase_next;
    logic [CMP_BITS-1:0] card_reg, card_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          timeout_reg;
    logic [1:0]          drive_reg, drive_next;
    logic                contactor_reg, contactor_next;
    logic                hatch_reg, hatch_next;
    logic [1:0]          chg_lamp_reg, chg_lamp_next;
    logic                avail_reg, avail_next;
    logic                fault_reg, fault_next;
    logic [1:0]          plug_reg, plug_next;
    logic [2:0]          prompt;

    always_comb begin
        logic [CMP_BITS-1:0] card_in;
        logic [7:0]          count_inc;
        logic                prompt_set;

        card_in        = in_data.card_number[CMP_BITS-1:0];
        count_inc      = (count_reg != evcsc_pkg::COUNT_MAX) ? count_reg + 8'd1 : count_reg;
        prompt_set     = 1'b0;
        prompt         = evcsc_pkg::PR_NONE;
        phase_next     = phase_reg;
        card_next      = card_reg;
        count_next     = count_reg;
        drive_next     = drive_reg;
        contactor_next = contactor_reg;
        hatch_next     = hatch_reg;
        chg_lamp_next  = chg_lamp_reg;
        avail_next     = avail_reg;
        fault_next     = fault_reg;
        plug_next      = plug_reg;

        // Transition on this sample
        unique case (phase_reg)
            evcsc_pkg::PH_IDLE: begin
                if (in_data.card_inserted) begin
                    fault_next = 1'b0;
                    if (in_data.card_authorized) begin
                        card_next  = card_in;
                        count_next = 8'd0;
                        phase_next = evcsc_pkg::PH_WAIT;
                    end
                end
            end
            evcsc_pkg::PH_WAIT: begin
                count_next = count_inc;
                if (in_data.charge_pressed) begin
                    avail_next = 1'b0;
                    phase_next = evcsc_pkg::PH_A;
                end else if (count_inc >= timeout_reg) begin
                    chg_lamp_next = evcsc_pkg::LAMP_OFF;
                    fault_next    = 1'b1;
                    phase_next    = evcsc_pkg::PH_IDLE;
                    prompt        = evcsc_pkg::PR_REMOVE;
                    prompt_set    = 1'b1;
                end
            end
            evcsc_pkg::PH_A: begin
                if (in_data.pilot_volts == evcsc_pkg::VOLTS_9 &&
                    in_data.pilot_waveform == evcsc_pkg::WF_DC) begin
                    phase_next = evcsc_pkg::PH_B;
                end
            end
            evcsc_pkg::PH_B: begin
                if (in_data.pilot_volts == evcsc_pkg::VOLTS_9 &&
                    in_data.pilot_waveform == evcsc_pkg::WF_AC1K) begin
                    phase_next = evcsc_pkg::PH_C;
                end else if (in_data.stop_pressed) begin
                    phase_next = evcsc_pkg::PH_E;
                end
            end
            evcsc_pkg::PH_C: begin
                if (in_data.pilot_volts == evcsc_pkg::VOLTS_6) begin
                    phase_next = evcsc_pkg::PH_D;
                end else if (in_data.stop_pressed) begin
                    phase_next = evcsc_pkg::PH_E;
                end
            end
            evcsc_pkg::PH_D: begin
                if (in_data.stop_pressed ||
                    (in_data.pilot_volts == evcsc_pkg::VOLTS_9 &&
                     in_data.pilot_waveform != evcsc_pkg::WF_DC)) begin
                    phase_next = evcsc_pkg::PH_E;
                end
            end
            evcsc_pkg::PH_E: begin
                if (in_data.pilot_waveform == evcsc_pkg::WF_DC) begin
                    phase_next = evcsc_pkg::PH_F;
                end
            end
            evcsc_pkg::PH_F: begin
                if (in_data.card_inserted) begin
                    if (card_in != card_reg) begin
                        prompt     = evcsc_pkg::PR_WRONG_VEH;
                        prompt_set = 1'b1;
                    end else if (in_data.card_authorized) begin
                        chg_lamp_next = evcsc_pkg::LAMP_OFF;
                        hatch_next    = 1'b0;
                        phase_next    = evcsc_pkg::PH_UNPLUG;
                    end else begin
                        phase_next = evcsc_pkg::PH_D;
                    end
                end
            end
            evcsc_pkg::PH_UNPLUG: begin
                if (in_data.pilot_volts == evcsc_pkg::VOLTS_12 &&
                    in_data.pilot_waveform == evcsc_pkg::WF_DC) begin
                    hatch_next = 1'b1;
                    plug_next  = evcsc_pkg::PLUG_RELEASED;
                    avail_next = 1'b1;
                    phase_next = evcsc_pkg::PH_IDLE;
                    prompt     = evcsc_pkg::PR_REMOVE;
                    prompt_set = 1'b1;
                end
            end
            default: begin
                phase_next = evcsc_pkg::PH_IDLE;
            end
        endcase

        // Outputs set by the phase reached
        unique case (phase_next)
            evcsc_pkg::PH_WAIT: begin
                chg_lamp_next = evcsc_pkg::LAMP_BLINK;
            end
            evcsc_pkg::PH_A: begin
                chg_lamp_next = evcsc_pkg::LAMP_RED;
                hatch_next    = 1'b0;
                drive_next    = evcsc_pkg::DRV_DC12;
            end
            evcsc_pkg::PH_B: begin
                plug_next  = evcsc_pkg::PLUG_GREEN;
                hatch_next = 1'b1;
                drive_next = evcsc_pkg::DRV_AC1K;
            end
            evcsc_pkg::PH_C: begin
                contactor_next = 1'b1;
                drive_next     = evcsc_pkg::DRV_CLOSED;
            end
            evcsc_pkg::PH_D: begin
                drive_next = evcsc_pkg::DRV_CLOSED;
            end
            evcsc_pkg::PH_E: begin
                contactor_next = 1'b0;
                chg_lamp_next  = evcsc_pkg::LAMP_GREEN;
                drive_next     = evcsc_pkg::DRV_DC12;
            end
            default: begin
            end
        endcase

        if (!prompt_set) begin
            unique case (phase_next)
                evcsc_pkg::PH_IDLE:   prompt = evcsc_pkg::PR_INSERT;
                evcsc_pkg::PH_A:      prompt = evcsc_pkg::PR_PLUG_IN;
                evcsc_pkg::PH_F:      prompt = evcsc_pkg::PR_INSERT;
                evcsc_pkg::PH_UNPLUG: prompt = evcsc_pkg::PR_UNPLUG;
                default:              prompt = evcsc_pkg::PR_NONE;
            endcase
        end
    end

    always_comb begin
        result.session_phase    = evcsc_pkg::phase_code(phase_next);
        result.pilot_drive      = drive_next;
        result.contactor_closed = contactor_next;
        result.hatch_locked     = hatch_next;
        result.charge_lamp      = chg_lamp_next;
        result.available_lamp   = avail_next;
        result.fault_lamp       = fault_next;
        result.plug_lamp        = plug_next;
        result.user_prompt      = prompt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= evcsc_pkg::PH_IDLE;
            count_reg     <= 8'd0;
            timeout_reg   <= evcsc_pkg::TIMEOUT_RESET;
            drive_reg     <= evcsc_pkg::DRV_NONE;
            contactor_reg <= 1'b0;
            hatch_reg     <= 1'b0;
            chg_lamp_reg  <= evcsc_pkg::LAMP_OFF;
            avail_reg     <= 1'b1;
            fault_reg     <= 1'b0;
            plug_reg      <= evcsc_pkg::PLUG_OFF;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (advance) begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                drive_reg     <= drive_next;
                contactor_reg <= contactor_next;
                hatch_reg     <= hatch_next;
                chg_lamp_reg  <= chg_lamp_next;
                avail_reg     <= avail_next;
                fault_reg     <= fault_next;
                plug_reg      <= plug_next;
            end
        end
    end

    // Session card holds no reset value; it is written before any read.
    always_ff @(posedge aclk) begin
        if (advance) begin
            card_reg <= card_next;
        end
    end

endmodule

[src/evcsc_out_stage.sv]
// ----------------------------------------------------------------------------
// evcsc_out_stage
// Result register: presents one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module evcsc_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  evcsc_pkg::out_item_t result,
    output logic                 m_valid,
    input  logic                 m_ready,
    output evcsc_pkg::out_item_t m_data,
    output logic                 out_free
);

    logic                 m_valid_reg;
    logic                 m_valid_next;
    evcsc_pkg::out_item_t m_data_reg;

    // Free when empty or when the held result transfers this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/evcsc_checker.sv]
// ----------------------------------------------------------------------------
// evcsc_checker
// Port-level checks of the charge session controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "ev_charge_session_controller_core_macros.svh"

module evcsc_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input evcsc_pkg::out_item_t m_data
);

    `EVCSC_ASSERT_RESET(a_no_result_after_reset, !aresetn |=> !m_valid, "result valid right after reset")

    `EVCSC_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    `EVCSC_ASSERT(a_idle_available, m_valid && m_data.session_phase == evcsc_pkg::PHC_IDLE |-> m_data.available_lamp, "idle without available lamp")

    `EVCSC_ASSERT(a_contactor_phase, m_valid && m_data.contactor_closed |-> m_data.session_phase == evcsc_pkg::PHC_C || m_data.session_phase == evcsc_pkg::PHC_D, "contactor closed outside C or D")

    `EVCSC_ASSERT(a_fault_in_idle, m_valid && m_data.fault_lamp |-> m_data.session_phase == evcsc_pkg::PHC_IDLE, "fault lamp outside idle")

endmodule

bind ev_charge_session_controller_core evcsc_checker u_evcsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/ev_charge_session_controller_checker.sv]
// ----------------------------------------------------------------------------
// ev_charge_session_controller_checker
// Watches both channels of the charge session controller and scores results.
// ----------------------------------------------------------------------------
// A session predictor tracks phase, held card, button wait count and output
// latches. It advances once per accepted sample and queues the expected
// result. Each accepted result is compared field by field against the oldest
// queued expectation. The failure count and the number of results still
// owed are handed to the testbench top.
module ev_charge_session_controller_checker
    import evcsc_pkg::*;
#(
    parameter int unsigned CARD_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_item_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_item_t  m_data,
    output int         fail_count,
    output int         outstanding,
    output int         results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Compare the whole card field when CARD_BITS covers it
    localparam logic [CARD_FIELD_BITS-1:0] CARD_MASK =
        (CARD_BITS >= CARD_FIELD_BITS) ? {CARD_FIELD_BITS{1'b1}} :
        {CARD_FIELD_BITS{1'b1}} >> (CARD_FIELD_BITS - CARD_BITS);

    // Predicted session state
    logic [3:0]                 ph;
    logic [CARD_FIELD_BITS-1:0] held_card;
    logic [7:0]                 wait_ticks;
    logic [7:0]                 button_limit;
    logic [1:0]                 drv;
    logic                       contact;
    logic                       hatch;
    logic [1:0]                 clamp;
    logic                       avail;
    logic                       fault;
    logic [1:0]                 plug;

    out_item_t expected_results[$];
    int        errors;
    int        checked;

    assign fail_count      = errors;
    assign results_checked = checked;

    task automatic predict_session(input in_item_t smp, output out_item_t res);
        logic [2:0] prompt;
        logic       named;
        prompt = PR_NONE;
        named  = 1'b0;
        case (ph)
            PHC_IDLE: begin
                if (smp.card_inserted) begin
                    fault = 1'b0;
                    if (smp.card_authorized) begin
                        held_card  = smp.card_number & CARD_MASK;
                        wait_ticks = '0;
                        ph         = PHC_WAIT;
                    end
                end
            end
            PHC_WAIT: begin
                if (wait_ticks != COUNT_MAX) begin
                    wait_ticks = wait_ticks + 8'd1;
                end
                // A press on the same tick beats the timeout
                if (smp.charge_pressed) begin
                    avail = 1'b0;
                    ph    = PHC_A;
                end else if (wait_ticks >= button_limit) begin
                    clamp  = LAMP_OFF;
                    fault  = 1'b1;
                    ph     = PHC_IDLE;
                    prompt = PR_REMOVE;
                    named  = 1'b1;
                end
            end
            PHC_A: begin
                if (smp.pilot_volts == VOLTS_9 && smp.pilot_waveform == WF_DC) begin
                    ph = PHC_B;
                end
            end
            PHC_B: begin
                if (smp.pilot_volts == VOLTS_9 && smp.pilot_waveform == WF_AC1K) begin
                    ph = PHC_C;
                end else if (smp.stop_pressed) begin
                    ph = PHC_E;
                end
            end
            PHC_C: begin
                if (smp.pilot_volts == VOLTS_6) begin
                    ph = PHC_D;
                end else if (smp.stop_pressed) begin
                    ph = PHC_E;
                end
            end
            PHC_D: begin
                if (smp.stop_pressed ||
                    (smp.pilot_volts == VOLTS_9 && smp.pilot_waveform != WF_DC)) begin
                    ph = PHC_E;
                end
            end
            PHC_E: begin
                if (smp.pilot_waveform == WF_DC) begin
                    ph = PHC_F;
                end
            end
            PHC_F: begin
                if (smp.card_inserted) begin
                    if ((smp.card_number & CARD_MASK) != held_card) begin
                        prompt = PR_WRONG_VEH;
                        named  = 1'b1;
                    end else if (smp.card_authorized) begin
                        clamp = LAMP_OFF;
                        hatch = 1'b0;
                        ph    = PHC_UNPLUG;
                    end else begin
                        ph = PHC_D;
                    end
                end
            end
            PHC_UNPLUG: begin
                if (smp.pilot_volts == VOLTS_12 && smp.pilot_waveform == WF_DC) begin
                    hatch  = 1'b1;
                    plug   = PLUG_RELEASED;
                    avail  = 1'b1;
                    ph     = PHC_IDLE;
                    prompt = PR_REMOVE;
                    named  = 1'b1;
                end
            end
            default: ph = PHC_IDLE;
        endcase

        // Latch the outputs of the phase just reached
        case (ph)
            PHC_WAIT: clamp = LAMP_BLINK;
            PHC_A: begin
                clamp = LAMP_RED;
                hatch = 1'b0;
                drv   = DRV_DC12;
            end
            PHC_B: begin
                plug  = PLUG_GREEN;
                hatch = 1'b1;
                drv   = DRV_AC1K;
            end
            PHC_C: begin
                contact = 1'b1;
                drv     = DRV_CLOSED;
            end
            PHC_D: drv = DRV_CLOSED;
            PHC_E: begin
                contact = 1'b0;
                clamp   = LAMP_GREEN;
                drv     = DRV_DC12;
            end
            default: ;
        endcase

        if (!named) begin
            case (ph)
                PHC_IDLE:   prompt = PR_INSERT;
                PHC_A:      prompt = PR_PLUG_IN;
                PHC_F:      prompt = PR_INSERT;
                PHC_UNPLUG: prompt = PR_UNPLUG;
                default:    prompt = PR_NONE;
            endcase
        end

        res.session_phase    = ph;
        res.pilot_drive      = drv;
        res.contactor_closed = contact;
        res.hatch_locked     = hatch;
        res.charge_lamp      = clamp;
        res.available_lamp   = avail;
        res.fault_lamp       = fault;
        res.plug_lamp        = plug;
        res.user_prompt      = prompt;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t fresh;
        if (!aresetn) begin
            ph           = PHC_IDLE;
            held_card    = '0;
            wait_ticks   = '0;
            button_limit = TIMEOUT_RESET;
            drv          = DRV_NONE;
            contact      = 1'b0;
            hatch        = 1'b0;
            clamp        = LAMP_OFF;
            avail        = 1'b1;
            fault        = 1'b0;
            plug         = PLUG_OFF;
            expected_results.delete();
            errors       = 0;
            checked      = 0;
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                button_limit = cfg_wr_data;
            end
            // Score the result transfer before queueing this edge's sample
            if (m_valid && m_ready) begin
                checked++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing queued, expected none, actual %p",
                             $time, m_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("session_phase", want.session_phase, m_data.session_phase);
                    check_field("pilot_drive", want.pilot_drive, m_data.pilot_drive);
                    check_field("contactor_closed", want.contactor_closed,
                                m_data.contactor_closed);
                    check_field("hatch_locked", want.hatch_locked, m_data.hatch_locked);
                    check_field("charge_lamp", want.charge_lamp, m_data.charge_lamp);
                    check_field("available_lamp", want.available_lamp,
                                m_data.available_lamp);
                    check_field("fault_lamp", want.fault_lamp, m_data.fault_lamp);
                    check_field("plug_lamp", want.plug_lamp, m_data.plug_lamp);
                    check_field("user_prompt", want.user_prompt, m_data.user_prompt);
                end
            end
            if (s_valid && s_ready) begin
                predict_session(s_data, fresh);
                expected_results.push_back(fresh);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

[tb/ev_charge_session_controller_core_test.sv]
// ----------------------------------------------------------------------------
// ev_charge_session_controller_core_test
// Testbench top for the charge session controller core.
// ----------------------------------------------------------------------------
// Drives a short directed walk through every session phase, then random
// charging sessions with noise, wrong cards, refused cards, early stops and
// button timeouts. Four pacing modes vary sender gaps and receiver stalls,
// and the button timeout is rewritten between modes while the block is
// drained. A checker module beside the block predicts and scores results.
module ev_charge_session_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import evcsc_pkg::*;

    localparam int unsigned CARD_BITS = 32;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_item_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_item_t  m_data;

    int fail_count;
    int outstanding;
    int results_checked;

    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         samples_sent   = 0;
    int         sessions_run   = 0;
    int         timeouts_run   = 0;
    logic [7:0] button_limit   = TIMEOUT_RESET;

    ev_charge_session_controller_core #(
        .CARD_BITS(CARD_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    ev_charge_session_controller_checker #(
        .CARD_BITS(CARD_BITS)
    ) scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .results_checked(results_checked)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still owed", outstanding);
        $display("FAIL");
        $finish;
    end

    function automatic in_item_t sample_of(logic [3:0] volts, logic [1:0] wf, logic stp,
                                           logic chg, logic cin, logic [31:0] num,
                                           logic auth);
        in_item_t smp;
        smp.pilot_volts     = volts;
        smp.pilot_waveform  = wf;
        smp.stop_pressed    = stp;
        smp.charge_pressed  = chg;
        smp.card_inserted   = cin;
        smp.card_number     = num;
        smp.card_authorized = auth;
        return smp;
    endfunction

    // Sample that moves no phase forward: no trigger level, no press,
    // no authorized card; DC and stop only where the caller allows them.
    function automatic in_item_t quiet_sample(bit dc_ok, bit stop_ok);
        in_item_t smp;
        smp.pilot_volts = 4'($urandom_range(15));
        if (smp.pilot_volts inside {VOLTS_6, VOLTS_9, VOLTS_12}) begin
            smp.pilot_volts = smp.pilot_volts + 4'd1;
        end
        smp.pilot_waveform  = dc_ok ? 2'($urandom_range(3)) : 2'($urandom_range(3, 1));
        smp.stop_pressed    = stop_ok ? 1'($urandom_range(1)) : 1'b0;
        smp.charge_pressed  = 1'b0;
        smp.card_inserted   = ($urandom_range(4) == 0);
        smp.card_number     = $urandom();
        smp.card_authorized = smp.card_inserted ? 1'b0 : 1'($urandom_range(1));
        return smp;
    endfunction

    task automatic send_sample(input in_item_t smp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic send_quiet(input int count, input bit dc_ok, input bit stop_ok);
        repeat (count) send_sample(quiet_sample(dc_ok, stop_ok));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_button_limit(input logic [7:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        button_limit  = value;
    endtask

    task automatic run_directed();
        send_sample(sample_of(4'd15, 2'd3, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample_of(4'd0, WF_DC, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b1));
        send_sample(sample_of(VOLTS_9, WF_DC, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(4'd0, WF_DC, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_9, WF_AC1K, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_9, WF_DC, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_9, WF_AC1K, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_6, 2'd2, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_9, 2'd3, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_12, 2'd3, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_12, WF_DC, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        // Wrong card, then the session card refused, then a stop out of D
        send_sample(sample_of(4'd0, WF_DC, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_sample(sample_of(4'd0, WF_DC, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b0));
        send_sample(sample_of(4'd0, WF_DC, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(4'd0, WF_DC, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(4'd0, WF_DC, 1'b1, 1'b1, 1'b0, 32'h0, 1'b1));
        send_sample(sample_of(4'd0, WF_DC, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b1));
        send_sample(sample_of(VOLTS_12, WF_AC1K, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_12, WF_DC, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        // Short session that stops in B
        send_sample(sample_of(4'd3, 2'd2, 1'b0, 1'b0, 1'b1, 32'h5A5A_A5A5, 1'b1));
        send_sample(sample_of(4'd3, 2'd2, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(VOLTS_9, WF_DC, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(4'd1, WF_AC1K, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(4'd1, WF_DC, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
        send_sample(sample_of(4'd1, WF_DC, 1'b0, 1'b0, 1'b1, 32'h5A5A_A5A5, 1'b1));
        send_sample(sample_of(VOLTS_12, WF_DC, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0));
    endtask

    task automatic run_session();
        in_item_t    smp;
        logic [31:0] card;
        int          kmax;
        int          choice;
        bit          released;
        card = $urandom();
        sessions_run++;

        // Idle noise: anything but an authorized card
        repeat ($urandom_range(3)) begin
            smp                 = sample_of(4'($urandom_range(15)), 2'($urandom_range(3)),
                                            1'($urandom_range(1)), 1'($urandom_range(1)),
                                            1'($urandom_range(1)), $urandom(), 1'b0);
            send_sample(smp);
        end
        smp                 = quiet_sample(1'b1, 1'b1);
        smp.card_inserted   = 1'b1;
        smp.card_number     = card;
        smp.card_authorized = 1'b1;
        send_sample(smp);

        if (button_limit <= 8'd12 && $urandom_range(3) == 0) begin
            send_quiet(button_limit, 1'b1, 1'b1);
            timeouts_run++;
            return;
        end
        kmax = (button_limit > 8'd11) ? 10 : button_limit - 1;
        // Sometimes press on the very tick the count reaches the limit
        send_quiet(($urandom_range(3) == 0) ? kmax : $urandom_range(kmax), 1'b1, 1'b1);
        smp                = quiet_sample(1'b1, 1'b1);
        smp.charge_pressed = 1'b1;
        send_sample(smp);

        // A: plugged at 9 V DC
        send_quiet($urandom_range(2), 1'b1, 1'b1);
        smp                = quiet_sample(1'b1, 1'b0);
        smp.pilot_volts    = VOLTS_9;
        smp.pilot_waveform = WF_DC;
        send_sample(smp);

        send_quiet($urandom_range(2), 1'b1, 1'b0);
        if ($urandom_range(4) != 0) begin
            smp                = quiet_sample(1'b1, 1'b1);
            smp.pilot_volts    = VOLTS_9;
            smp.pilot_waveform = WF_AC1K;
            send_sample(smp);
            send_quiet($urandom_range(2), 1'b1, 1'b0);
            smp = quiet_sample(1'b1, 1'b1);
            if ($urandom_range(4) == 0) begin
                smp.stop_pressed = 1'b1;
                send_sample(smp);
            end else begin
                smp.pilot_volts = VOLTS_6;
                send_sample(smp);
                send_quiet($urandom_range(3), 1'b1, 1'b0);
                smp = quiet_sample(1'b1, 1'b0);
                if ($urandom_range(1) == 0) begin
                    smp.stop_pressed = 1'b1;
                end else begin
                    smp.pilot_volts    = VOLTS_9;
                    smp.pilot_waveform = 2'($urandom_range(3, 1));
                end
                send_sample(smp);
            end
        end else begin
            smp              = quiet_sample(1'b1, 1'b0);
            smp.stop_pressed = 1'b1;
            send_sample(smp);
        end

        // E: hold off DC for a while, then release to F
        send_quiet($urandom_range(2), 1'b0, 1'b1);
        smp                = quiet_sample(1'b1, 1'b1);
        smp.pilot_waveform = WF_DC;
        send_sample(smp);

        released = 1'b0;
        while (!released) begin
            send_quiet($urandom_range(1), 1'b1, 1'b1);
            choice            = $urandom_range(5);
            smp               = quiet_sample(1'b1, 1'b1);
            smp.card_inserted = 1'b1;
            if (choice == 0) begin
                smp.card_number     = card ^ (32'd1 << $urandom_range(31));
                smp.card_authorized = 1'($urandom_range(1));
                send_sample(smp);
            end else if (choice == 1) begin
                // Refused session card drops back to D; stop and DC return to F
                smp.card_number     = card;
                smp.card_authorized = 1'b0;
                send_sample(smp);
                smp              = quiet_sample(1'b1, 1'b0);
                smp.stop_pressed = 1'b1;
                send_sample(smp);
                smp                = quiet_sample(1'b1, 1'b1);
                smp.pilot_waveform = WF_DC;
                send_sample(smp);
            end else begin
                smp.card_number     = card;
                smp.card_authorized = 1'b1;
                send_sample(smp);
                released = 1'b1;
            end
        end

        send_quiet($urandom_range(2), 1'b1, 1'b1);
        if ($urandom_range(2) == 0) begin
            smp                = quiet_sample(1'b1, 1'b1);
            smp.pilot_volts    = VOLTS_12;
            smp.pilot_waveform = 2'($urandom_range(3, 1));
            send_sample(smp);
        end
        smp                = quiet_sample(1'b1, 1'b1);
        smp.pilot_volts    = VOLTS_12;
        smp.pilot_waveform = WF_DC;
        send_sample(smp);
    endtask

    task automatic run_pacing(input int src_pct, input int sink_pct,
                              input logic [7:0] limit, input int target);
        write_button_limit(limit);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (samples_sent < target) run_session();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_pacing(0, 0, 8'd1, 150);
        run_pacing(74, 0, 8'd255, 280);
        run_pacing(0, 74, 8'($urandom_range(12, 2)), 410);
        run_pacing(35, 35, 8'($urandom_range(255, 1)), 530);

        drain_results();
        $display("Ran %0d samples in %0d sessions (%0d button timeouts), %0d results checked",
                 samples_sent, sessions_run, timeouts_run, results_checked);
        $display("Covered all phases, card mismatch and refusal, four pacing modes, %0d errors",
                 fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/evcsc_pkg.sv
src/evcsc_in_stage.sv
src/evcsc_session.sv
src/evcsc_out_stage.sv
src/ev_charge_session_controller_core.sv
src/evcsc_checker.sv
tb/ev_charge_session_controller_checker.sv
tb/ev_charge_session_controller_core_test.sv
